### rtl/core/dvsp_pkg.sv
// Package for the dotted decimal version string parser.
// Holds the part count, character codes and the character class helpers.
// No dependencies; used by rtl/core/dotted_version_string_parser.sv.
package dvsp_pkg;

    // Number of dot-separated parts and the width of each one.
    localparam int unsigned NumParts  = 4;
    localparam int unsigned PartWidth = 32;
    localparam int unsigned IdxWidth  = $clog2(NumParts);

    // Character codes that the parser tests for.
    localparam logic [7:0] DotCode    = 8'd46;
    localparam logic [7:0] ZeroCode   = 8'd48;
    localparam logic [7:0] NineCode   = 8'd57;
    localparam logic [7:0] SpaceCode  = 8'd32;
    localparam logic [7:0] TabCode    = 8'd9;
    localparam logic [7:0] CrCode     = 8'd13;

    typedef logic [PartWidth-1:0] t_part;
    typedef logic [IdxWidth-1:0]  t_part_idx;

    // Whitespace is tab through carriage return, and space.
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == SpaceCode) || ((c >= TabCode) && (c <= CrCode));
    endfunction

    // Decimal digits are the ASCII codes of 0 through 9 only.
    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= ZeroCode) && (c <= NineCode);
    endfunction

    // One accumulation step: value * 10 + digit, wrapping at the part width.
    function automatic t_part mac10(input t_part v, input logic [7:0] c);
        logic [3:0] d;
        d = 4'(c - ZeroCode);
        mac10 = (v << 3) + (v << 1) + t_part'(d);
    endfunction

endpackage

### rtl/core/dotted_version_string_parser.sv
// Dotted decimal version string parser, top level.
// Depends on rtl/core/dvsp_pkg.sv for constants, types and character tests.
//
// Usage:
//   Characters of a version string enter on the input channel (i_in_valid,
//   o_in_stall, i_char_code, i_last_char), one transfer per character, with
//   i_last_char set on the final character. Up to four dot-separated decimal
//   parts are parsed; each wraps modulo 2^32. Whitespace may pad the string
//   and each part. The final character produces one result transfer on the
//   output channel (o_out_valid, i_out_stall, four parts and o_is_valid);
//   all parts read zero when the string is rejected.
//   Throughput is one character per cycle unless the input stalls. A
//   character is held in the input register, and the whole per-character
//   update (one shift-and-add multiply by ten and the class tests) runs in
//   the cycle it leaves that register, so a final character passes through
//   the input register and then the result register before its result shows.
//   A synchronous active-low reset empties both registers and clears the
//   parse state. While the receiver stalls, the result register holds its
//   transfer; characters keep flowing until a second final character waits,
//   which then stalls the input.
module dotted_version_string_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_major_part,
    output logic [31:0] o_minor_part,
    output logic [31:0] o_patch_part,
    output logic [31:0] o_build_part,
    output logic        o_is_valid
);

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    // Parse state.
    dvsp_pkg::t_part     r_part [dvsp_pkg::NumParts];
    dvsp_pkg::t_part     n_part [dvsp_pkg::NumParts];
    dvsp_pkg::t_part_idx r_part_index, n_part_index;
    logic                r_part_empty, n_part_empty;
    logic                r_dot_pending, n_dot_pending;
    logic                r_part_closed, n_part_closed;
    logic                r_error_seen, n_error_seen;

    // Result register.
    logic                r_out_valid;
    dvsp_pkg::t_part     r_out_part [dvsp_pkg::NumParts];
    logic                r_out_ok;

    logic                advance;
    logic                in_take;
    logic                out_free;
    logic                ok;
    dvsp_pkg::t_part     cur_part;

    // The result register can take a new result when empty or draining.
    assign out_free   = !r_out_valid || !i_out_stall;
    // A held character moves on unless it is a final one facing a full output.
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Per-character state update.
    always_comb begin
        n_part        = r_part;
        n_part_index  = r_part_index;
        n_part_empty  = r_part_empty;
        n_dot_pending = r_dot_pending;
        n_part_closed = r_part_closed;
        n_error_seen  = r_error_seen;
        cur_part      = r_part[r_part_index];
        if (!r_error_seen) begin
            priority if (r_in_char == dvsp_pkg::DotCode) begin
                if (r_part_empty ||
                    r_part_index == dvsp_pkg::t_part_idx'(dvsp_pkg::NumParts - 1)) begin
                    n_error_seen = 1'b1;
                end else begin
                    n_part_index  = r_part_index + dvsp_pkg::t_part_idx'(1);
                    n_part_empty  = 1'b1;
                    n_part_closed = 1'b0;
                    n_dot_pending = 1'b1;
                end
            end else if (dvsp_pkg::is_blank(r_in_char)) begin
                if (!r_part_empty) begin
                    n_part_closed = 1'b1;
                end
            end else if (dvsp_pkg::is_digit(r_in_char)) begin
                if (r_part_closed) begin
                    n_error_seen = 1'b1;
                end else begin
                    n_part[r_part_index] = dvsp_pkg::mac10(cur_part, r_in_char);
                    n_part_empty         = 1'b0;
                    n_dot_pending        = 1'b0;
                end
            end else begin
                n_error_seen = 1'b1;
            end
        end
        // The string is good when nothing rejected it, it did not end on a
        // dot, and it held at least one digit.
        ok = !n_error_seen && !n_dot_pending && !((n_part_index == '0) && n_part_empty);
    end

    // Input register: loads on every input transfer, empties as it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    // Parse state: updated per character, cleared after the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            for (int k = 0; k < dvsp_pkg::NumParts; k++) begin
                r_part[k] <= '0;
            end
            r_part_index  <= '0;
            r_part_empty  <= 1'b1;
            r_dot_pending <= 1'b0;
            r_part_closed <= 1'b0;
            r_error_seen  <= 1'b0;
        end else if (advance) begin
            r_part        <= n_part;
            r_part_index  <= n_part_index;
            r_part_empty  <= n_part_empty;
            r_dot_pending <= n_dot_pending;
            r_part_closed <= n_part_closed;
            r_error_seen  <= n_error_seen;
        end
    end

    // Result register: loads on a final character, empties on a transfer out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            for (int k = 0; k < dvsp_pkg::NumParts; k++) begin
                r_out_part[k] <= ok ? n_part[k] : '0;
            end
            r_out_ok <= ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_major_part = r_out_part[0];
    assign o_minor_part = r_out_part[1];
    assign o_patch_part = r_out_part[2];
    assign o_build_part = r_out_part[3];
    assign o_is_valid   = r_out_ok;

    // A rejected result carries all-zero parts.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |->
            (r_out_part[0] == '0 && r_out_part[1] == '0 &&
             r_out_part[2] == '0 && r_out_part[3] == '0))
        else $error("rejected result with nonzero parts");

    // A final character that advances always lands in the result register.
    a_last_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> r_out_valid)
        else $error("final character produced no result");

    // The parse state is back at its start after a final character.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=>
            (r_part_index == '0 && r_part_empty && !r_error_seen &&
             !r_dot_pending && !r_part_closed))
        else $error("parse state not cleared after final character");

    // The input only stalls for a waiting final character and a full output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid && i_out_stall))
        else $error("input stalled without cause");

endmodule
